@@ rtl/core/csp_pkg.sv @@
// ============================================================================
// csp_pkg: shared types, constants and a function for the C source prefilter
// Holds the character codes, the filter state encodings, the result types
// and the blank/directive filter step.
// ============================================================================
`default_nettype none

package csp_pkg;

  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharHash    = 8'h23;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;

  // Results one item can cause: flushed slash, the byte, the end marker.
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  typedef enum logic [2:0] {
    CM_NORMAL = 3'd0,
    CM_SLASH  = 3'd1,
    CM_LINE   = 3'd2,
    CM_BLOCK  = 3'd3,
    CM_BSTAR  = 3'd4
  } cm_e;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_SPACES = 2'd1,
    BR_TABS   = 2'd2
  } br_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_end;
    logic       stream_end;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [CntW-1:0]   cnt;
  } batch_t;

  typedef struct packed {
    br_e        br;
    logic       dir;
    logic       emit;
    logic [7:0] ch;
  } step_t;

  // One character through the blank filter and then the directive filter.
  function automatic step_t blank_step(br_e br, logic dir, logic [7:0] c);
    step_t      s;
    logic       fwd;
    logic [7:0] d;
    s.br   = br;
    s.dir  = dir;
    s.emit = 1'b0;
    fwd    = 1'b0;
    d      = c;
    if (c == CharSpace) begin
      if (br != BR_SPACES) begin
        s.br = BR_SPACES;
        fwd  = 1'b1;
      end
    end else if (c == CharTab) begin
      if (br != BR_TABS) begin
        s.br = BR_TABS;
        fwd  = 1'b1;
        d    = CharSpace;
      end
    end else begin
      s.br = BR_NONE;
      fwd  = 1'b1;
    end
    if (fwd) begin
      if (dir) begin
        if (d == CharNewline) begin
          s.dir  = 1'b0;
          s.emit = 1'b1;
        end
      end else if (d == CharHash) begin
        s.dir = 1'b1;
      end else begin
        s.emit = 1'b1;
      end
    end
    s.ch = d;
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/csp_filter.sv @@
// ============================================================================
// csp_filter: comment, blank and directive filters with their state
// Turns one accepted byte into a batch of up to three results and
// updates the filter state on the same edge.
// ============================================================================
`default_nettype none

module csp_filter import csp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_file_i,
  output batch_t          batch_o
);

  cm_e  cm_q, cm_d;
  br_e  br_q, br_d;
  logic dir_q, dir_d;

  logic       f0, f1;
  logic [7:0] c0, c1;
  step_t      s0, s1;
  logic       e0, e1;
  logic [7:0] o0, o1;

  always_comb begin
    cm_d = cm_q;
    f0   = 1'b0;
    f1   = 1'b0;
    c0   = in_char_i;
    c1   = in_char_i;
    unique case (cm_q)
      CM_SLASH: begin
        if (in_char_i == CharSlash) begin
          cm_d = CM_LINE;
        end else if (in_char_i == CharStar) begin
          cm_d = CM_BLOCK;
        end else begin
          cm_d = CM_NORMAL;
          f0   = 1'b1;
          c0   = CharSlash;
          f1   = 1'b1;
        end
      end
      CM_LINE: begin
        if (in_char_i == CharNewline) begin
          cm_d = CM_NORMAL;
          f0   = 1'b1;
        end
      end
      CM_BLOCK: begin
        if (in_char_i == CharStar) cm_d = CM_BSTAR;
      end
      CM_BSTAR: begin
        if (in_char_i == CharSlash) cm_d = CM_NORMAL;
        else if (in_char_i != CharStar) cm_d = CM_BLOCK;
      end
      default: begin
        if (in_char_i == CharSlash) begin
          cm_d = CM_SLASH;
        end else begin
          cm_d = CM_NORMAL;
          f0   = 1'b1;
        end
      end
    endcase
    // flush a held slash on the last beat
    if (end_of_file_i && cm_d == CM_SLASH) begin
      cm_d = CM_NORMAL;
      f0   = 1'b1;
      c0   = CharSlash;
    end

    s0 = blank_step(br_q, dir_q, c0);
    if (!f0) s0 = '{br: br_q, dir: dir_q, emit: 1'b0, ch: c0};
    s1 = blank_step(s0.br, s0.dir, c1);
    if (!f1) s1 = '{br: s0.br, dir: s0.dir, emit: 1'b0, ch: c1};

    e0 = s0.emit;
    e1 = s1.emit;
    o0 = s0.ch;
    o1 = s1.ch;
    br_d  = s1.br;
    dir_d = s1.dir;

    // pack characters to the front, then the end marker
    batch_o.res = '0;
    if (e0) begin
      batch_o.res[0] = '{ch: o0, has_char: 1'b1, run_end: 1'b0, stream_end: 1'b0};
      batch_o.res[1] = '{ch: o1, has_char: 1'b1, run_end: 1'b0, stream_end: 1'b0};
    end else begin
      batch_o.res[0] = '{ch: o1, has_char: 1'b1, run_end: 1'b0, stream_end: 1'b0};
    end
    batch_o.cnt = CntW'(e0) + CntW'(e1);
    if (end_of_file_i) begin
      batch_o.res[batch_o.cnt[1:0]] =
        '{ch: 8'h00, has_char: 1'b0, run_end: 1'b0, stream_end: 1'b1};
      batch_o.cnt = batch_o.cnt + CntW'(1);
    end
    if (batch_o.cnt != '0) batch_o.res[batch_o.cnt[1:0] - 2'd1].run_end = 1'b1;

    // the end marker returns the stream to its reset state
    if (end_of_file_i) begin
      cm_d  = CM_NORMAL;
      br_d  = BR_NONE;
      dir_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q  <= CM_NORMAL;
      br_q  <= BR_NONE;
      dir_q <= 1'b0;
    end else if (accept_i) begin
      cm_q  <= cm_d;
      br_q  <= br_d;
      dir_q <= dir_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/csp_outbuf.sv @@
// ============================================================================
// csp_outbuf: result register for the prefilter
// Holds one batch of up to three results and hands them out one per beat.
// ============================================================================
`default_nettype none

module csp_outbuf import csp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire batch_t batch_i,
  input  wire logic   out_ready_i,
  output logic        can_load_o,
  output logic        out_valid_o,
  output res_t        front_o
);

  res_t [MaxRes-1:0] ent_q, ent_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // empty, or the last entry leaves on this edge
  assign can_load_o  = (cnt_q == '0) || (cnt_q == CntW'(1) && out_ready_i);
  assign front_o     = ent_q[0];

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = batch_i.res;
      cnt_d = batch_i.cnt;
    end else if (pop) begin
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/c_source_prefilter.sv @@
// ============================================================================
// c_source_prefilter: streaming prefilter for C source text
// Strips comments, collapses blank runs and drops directive lines.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one source byte per beat,
//   with end_of_file_i set on the final byte of a stream.
//   Output channel (out_valid_o/out_ready_i) gives zero to three result
//   beats per input beat: filtered characters (has_char_o = 1), and after
//   the final byte an end marker (stream_end_o = 1). run_end_o flags the
//   last result beat caused by one input beat.
//   The results of a byte are registered and appear in the cycle after its beat is taken.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and the receiver is ready. A byte that yields two or three
//   results holds the input while the single result register drains
//   one beat per ready cycle; a byte that yields nothing waits too.
//   When the receiver stalls, the result register holds and in_ready_o
//   drops once a further batch could not be placed.
//   Reset clears the filter state (normal text, no blank run, no
//   directive) and empties the result register. After an end marker the
//   filter state returns to reset and the next byte opens a new stream.
// ============================================================================
`default_nettype none

module c_source_prefilter import csp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_file_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            has_char_o,
  output logic            run_end_o,
  output logic            stream_end_o
);

  logic   accept;
  batch_t batch;
  res_t   front;

  // a beat is taken whenever the result register can hold its batch
  assign accept = in_valid_i && in_ready_o;

  csp_filter u_filter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .in_char_i     (in_char_i),
    .end_of_file_i (end_of_file_i),
    .batch_o       (batch)
  );

  csp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .batch_i     (batch),
    .out_ready_i (out_ready_i),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .front_o     (front)
  );

  assign out_char_o   = front.ch;
  assign has_char_o   = front.has_char;
  assign run_end_o    = front.run_end;
  assign stream_end_o = front.stream_end;

  // end marker carries no character and closes its run
  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> !has_char_o && run_end_o)
    else $error("end marker malformed");

  // a final byte always produces at least the end marker
  a_eof_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_file_i |=> out_valid_o)
    else $error("final byte gave no result");

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

endmodule

`default_nettype wire

@@ tb/c_source_prefilter_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// c_source_prefilter_tb: self-checking bench for the C source prefilter
// Feeds byte streams through the input channel. A directed table covers the
// corner cases first, then random streams follow, built from C-like tokens
// with noise mixed in. Each accepted byte runs through a behavioral copy of
// the comment, blank and directive filters. Every result beat is compared
// field by field against the oldest predicted beat.
// ============================================================================

module c_source_prefilter_tb;

  import csp_pkg::*;

  // Run shape
  localparam int RandItems  = 433;   // least bytes in the random part
  localparam int HoldCycles = 64;    // long receiver hold-off
  localparam int StallLimit = 1000;  // cycles with no beat on either side
  localparam int DrainWait  = 10;    // settle time after the last result

  // Token kinds for the random stream builder
  typedef enum int {
    TK_WORD,
    TK_SPACES,
    TK_TABS,
    TK_NEWLINE,
    TK_LINE_CMT,
    TK_BLOCK_CMT,
    TK_DIRECTIVE,
    TK_SLASH,
    TK_NOISE
  } tok_e;

  // Receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_COIN,
    RX_MOSTLY,
    RX_THIRDS
  } rx_mode_e;

  // One directed row: the byte, the end flag and, for rows marked typed,
  // the characters expected before any end marker.
  typedef struct packed {
    logic [7:0] ch;
    logic       eof;
    logic       typed;
    logic [1:0] n;
    logic [7:0] c0;
    logic [7:0] c1;
  } dir_row_t;

  localparam int NumDir = 27;

  // Rows that are not typed are checked against the filter model alone.
  dir_row_t dir_rows [NumDir] = '{
    '{8'h00,       1'b0, 1'b1, 2'd1, 8'h00,       8'h00},  // lowest byte
    '{8'hFF,       1'b0, 1'b1, 2'd1, 8'hFF,       8'h00},  // highest byte
    '{CharSlash,   1'b0, 1'b1, 2'd0, 8'h00,       8'h00},  // slash held
    '{8'h61,       1'b0, 1'b1, 2'd2, CharSlash,   8'h61},  // held slash + 'a'
    '{CharSlash,   1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{CharSlash,   1'b0, 1'b1, 2'd0, 8'h00,       8'h00},  // line comment
    '{8'h78,       1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{CharNewline, 1'b0, 1'b1, 2'd1, CharNewline, 8'h00},  // newline kept
    '{CharSpace,   1'b0, 1'b1, 2'd1, CharSpace,   8'h00},
    '{CharSpace,   1'b0, 1'b1, 2'd0, 8'h00,       8'h00},  // run collapsed
    '{CharTab,     1'b0, 1'b1, 2'd1, CharSpace,   8'h00},  // tab run touches
    '{CharTab,     1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{CharStar,    1'b0, 1'b0, 2'd0, 8'h00,       8'h00},  // block opens
    '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00,       8'h00},  // no close yet
    '{CharStar,    1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{CharStar,    1'b0, 1'b0, 2'd0, 8'h00,       8'h00},  // star run
    '{CharSlash,   1'b0, 1'b0, 2'd0, 8'h00,       8'h00},  // closes
    '{CharHash,    1'b0, 1'b1, 2'd0, 8'h00,       8'h00},  // directive
    '{CharSpace,   1'b0, 1'b0, 2'd0, 8'h00,       8'h00},
    '{CharNewline, 1'b0, 1'b1, 2'd1, CharNewline, 8'h00},  // newline kept
    '{8'h62,       1'b0, 1'b1, 2'd1, 8'h62,       8'h00},
    '{CharSlash,   1'b1, 1'b1, 2'd1, CharSlash,   8'h00},  // slash flushed
    '{CharSlash,   1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{CharStar,    1'b0, 1'b1, 2'd0, 8'h00,       8'h00},
    '{8'h7A,       1'b1, 1'b1, 2'd0, 8'h00,       8'h00},  // open block lost
    '{CharTab,     1'b1, 1'b1, 2'd1, CharSpace,   8'h00}   // one-byte stream
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_char_i;
  logic       end_of_file_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       has_char_o;
  logic       run_end_o;
  logic       stream_end_o;

  // Filter model state
  cm_e        cm_q;
  br_e        br_q;
  logic       dir_q;
  logic [7:0] emit_q[$];     // characters one byte lets through
  res_t       pending_res[$]; // result beats still to arrive

  int   errors;
  int   n_results;
  int   n_markers;
  int   burst_left;
  bit   hold_req;
  res_t want;

  c_source_prefilter i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_char_i    (in_char_i),
    .end_of_file_i(end_of_file_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .has_char_o   (has_char_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Filter model. Last stage first: drops '#' lines, keeps their newline.
  // --------------------------------------------------------------------------
  task automatic directive_pass(input logic [7:0] c);
    if (dir_q) begin
      if (c == CharNewline) begin
        dir_q = 1'b0;
        emit_q.push_back(c);
      end
    end else if (c == CharHash) begin
      dir_q = 1'b1;
    end else begin
      emit_q.push_back(c);
    end
  endtask

  // Space runs and tab runs each become one space; a switch between the
  // two kinds starts a new run.
  task automatic blank_pass(input logic [7:0] c);
    if (c == CharSpace) begin
      if (br_q != BR_SPACES) begin
        br_q = BR_SPACES;
        directive_pass(CharSpace);
      end
    end else if (c == CharTab) begin
      if (br_q != BR_TABS) begin
        br_q = BR_TABS;
        directive_pass(CharSpace);
      end
    end else begin
      br_q = BR_NONE;
      directive_pass(c);
    end
  endtask

  // The byte after a held slash bypasses the opener check on purpose.
  task automatic comment_pass(input logic [7:0] c);
    case (cm_q)
      CM_SLASH: begin
        if (c == CharSlash) begin
          cm_q = CM_LINE;
        end else if (c == CharStar) begin
          cm_q = CM_BLOCK;
        end else begin
          cm_q = CM_NORMAL;
          blank_pass(CharSlash);
          blank_pass(c);
        end
      end
      CM_LINE: begin
        if (c == CharNewline) begin
          cm_q = CM_NORMAL;
          blank_pass(c);
        end
      end
      CM_BLOCK: begin
        if (c == CharStar) cm_q = CM_BSTAR;
      end
      CM_BSTAR: begin
        if (c == CharSlash) cm_q = CM_NORMAL;
        else if (c != CharStar) cm_q = CM_BLOCK;
      end
      default: begin
        if (c == CharSlash) begin
          cm_q = CM_SLASH;
        end else begin
          cm_q = CM_NORMAL;
          blank_pass(c);
        end
      end
    endcase
  endtask

  // Whole model step for one byte: fills emit_q, flushes a held slash at
  // the end of a stream.
  task automatic filter_byte(input logic [7:0] c, input logic eof);
    emit_q.delete();
    comment_pass(c);
    if (eof && cm_q == CM_SLASH) begin
      cm_q = CM_NORMAL;
      blank_pass(CharSlash);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them. Payload
  // changes at the falling edge only; valid holds until the beat is taken.
  // On acceptance the expected beats are queued.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic eof, input logic typed,
                           input logic [1:0] n, input logic [7:0] c0,
                           input logic [7:0] c1);
    int   gap;
    int   k;
    int   total;
    res_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    in_char_i     <= c;
    end_of_file_i <= eof;
    do @(posedge clk_i); while (!in_ready_o);

    filter_byte(c, eof);
    // Typed rows override the model output but still advance its state.
    if (typed) begin
      emit_q.delete();
      if (n > 0) emit_q.push_back(c0);
      if (n > 1) emit_q.push_back(c1);
    end
    total = emit_q.size() + (eof ? 1 : 0);
    for (k = 0; k < emit_q.size(); k++) begin
      r.ch         = emit_q[k];
      r.has_char   = 1'b1;
      r.run_end    = (k == total - 1);
      r.stream_end = 1'b0;
      pending_res.push_back(r);
    end
    if (eof) begin
      r.ch         = 8'h00;
      r.has_char   = 1'b0;
      r.run_end    = 1'b1;
      r.stream_end = 1'b1;
      pending_res.push_back(r);
      // end marker puts the filters back to their reset state
      cm_q  = CM_NORMAL;
      br_q  = BR_NONE;
      dir_q = 1'b0;
    end
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: switches between stall patterns of random length. When the
  // stimulus asks, it holds ready low for HoldCycles so the result register
  // fills and the input side has to stall.
  // --------------------------------------------------------------------------
  initial begin : rx_side
    rx_mode_e mode;
    int       mode_left;
    int       phase;
    out_ready_i = 1'b0;
    mode        = RX_FREE;
    mode_left   = 0;
    phase       = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, RX_THIRDS));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_FREE:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:   out_ready_i <= (phase % 3 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: sampled at the rising edge, one expected beat per
  // accepted result beat, oldest first.
  // --------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (stream_end_o === 1'b1) n_markers++;
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got ch=%h has=%b end=%b/%b",
                 $time, out_char_o, has_char_o, run_end_o, stream_end_o);
        errors++;
      end else begin
        want = pending_res.pop_front();
        check_field("out_char",   want.ch,         out_char_o);
        check_field("has_char",   want.has_char,   has_char_o);
        check_field("run_end",    want.run_end,    run_end_o);
        check_field("stream_end", want.stream_end, stream_end_o);
      end
    end
  end

  // Watchdog: cycles without a beat on either channel.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding",
             $time, StallLimit, pending_res.size());
    $display("c_source_prefilter_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random C-like streams. Every
  // stream closes with end_of_file on its last byte.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] text[$];
    tok_e       tok;
    int         target;
    int         k;
    int         rnd_sent;
    int         streams;
    bit         hold_done;

    errors        = 0;
    n_results     = 0;
    n_markers     = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    rnd_sent      = 0;
    streams       = 0;
    cm_q          = CM_NORMAL;
    br_q          = BR_NONE;
    dir_q         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_char_i     = 8'h00;
    end_of_file_i = 1'b0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < NumDir; k++) begin
      send_beat(dir_rows[k].ch, dir_rows[k].eof, dir_rows[k].typed,
                dir_rows[k].n, dir_rows[k].c0, dir_rows[k].c1);
    end

    while (rnd_sent < RandItems) begin
      text.delete();
      // mostly mid-sized streams, now and then a very short one
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(6, 40);
      while (text.size() < target) begin
        tok = tok_e'($urandom_range(0, TK_NOISE));
        case (tok)
          TK_WORD: begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(8'h21, 8'h7E)));
          end
          TK_SPACES: repeat ($urandom_range(1, 4)) text.push_back(CharSpace);
          TK_TABS:   repeat ($urandom_range(1, 4)) text.push_back(CharTab);
          TK_NEWLINE: text.push_back(CharNewline);
          TK_LINE_CMT: begin
            text.push_back(CharSlash);
            text.push_back(CharSlash);
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 4) != 0) text.push_back(CharNewline);
          end
          TK_BLOCK_CMT: begin
            text.push_back(CharSlash);
            text.push_back(CharStar);
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 3))
                0:       text.push_back(CharStar);
                1:       text.push_back(CharSlash);
                2:       text.push_back(8'($urandom_range(8'h20, 8'h7E)));
                default: text.push_back(8'($urandom_range(0, 255)));
              endcase
            end
            if ($urandom_range(0, 4) != 0) begin
              repeat ($urandom_range(1, 3)) text.push_back(CharStar);
              text.push_back(CharSlash);
            end
          end
          TK_DIRECTIVE: begin
            text.push_back(CharHash);
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            if ($urandom_range(0, 4) != 0) text.push_back(CharNewline);
          end
          TK_SLASH: begin
            text.push_back(CharSlash);
            text.push_back(8'($urandom_range(0, 255)));
          end
          default: text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      // a trailing lone slash exercises the flush at end of stream
      if ($urandom_range(0, 5) == 0) text.push_back(CharSlash);

      for (k = 0; k < text.size(); k++) begin
        send_beat(text[k], (k == text.size() - 1), 1'b0, 2'd0, 8'h00, 8'h00);
      end
      rnd_sent += text.size();
      streams++;

      if (!hold_done && rnd_sent >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d bytes (%0d directed, %0d random in %0d streams).",
             NumDir + rnd_sent, NumDir, rnd_sent, streams);
    $display("Checked %0d result beats including %0d end markers; %0d mismatches.",
             n_results, n_markers, errors);
    if (errors == 0) begin
      $display("c_source_prefilter_tb: clean");
    end else begin
      $display("c_source_prefilter_tb: errors");
    end
    $finish;
  end

endmodule
